### hw/rtl/iteration_palette_color_defines.svh
// Assertion macros for the iteration palette color block.
// Included by the top level; the macros expand to nothing when SYNTH is set.
`ifndef ITERATION_PALETTE_COLOR_DEFINES_SVH
`define ITERATION_PALETTE_COLOR_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define IPC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iteration_palette_color: same-cycle check failed");
// next-cycle implication
`define IPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iteration_palette_color: next-cycle check failed");
`else
`define IPC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define IPC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/ipc_pkg.sv
// Shared types, codes and constant tables of the iteration palette color block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ipc_pkg;

  localparam int LIMIT_BITS   = 16;
  localparam int PAL_BITS     = 2;
  localparam int REG_IDX_BITS = 1;
  localparam int CHAN_N       = 3;
  localparam int STEP_N       = 4;
  localparam int SCALE_BITS   = 13;

  // register indexes
  localparam logic [REG_IDX_BITS-1:0] REG_LIMIT   = 1'b0;
  localparam logic [REG_IDX_BITS-1:0] REG_PALETTE = 1'b1;

  // palette codes; any other code behaves as PAL_2
  localparam logic [PAL_BITS-1:0] PAL_0 = 2'd0;
  localparam logic [PAL_BITS-1:0] PAL_1 = 2'd1;
  localparam logic [PAL_BITS-1:0] PAL_2 = 2'd2;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd100;

  // factor fed to a multiply step
  typedef enum logic [1:0] {
    FAC_T,
    FAC_U,
    FAC_ONE
  } fac_t;

  typedef fac_t [CHAN_N-1:0] fac_set_t;

  // 2K * 255 per channel: red 18*255, green 30*255, blue 17*255
  localparam logic [SCALE_BITS-1:0] SCALE [CHAN_N] = '{13'd4590, 13'd7650, 13'd4335};

  // operand order per palette, channel and step; step 0 is the start value
  localparam fac_t FAC_TAB [3][CHAN_N][STEP_N] = '{
    '{'{FAC_U, FAC_T, FAC_T, FAC_T},
      '{FAC_U, FAC_U, FAC_T, FAC_T},
      '{FAC_U, FAC_U, FAC_U, FAC_T}},
    '{'{FAC_T, FAC_T, FAC_U, FAC_ONE},
      '{FAC_T, FAC_U, FAC_U, FAC_ONE},
      '{FAC_T, FAC_T, FAC_T, FAC_ONE}},
    '{'{FAC_U, FAC_U, FAC_U, FAC_T},
      '{FAC_U, FAC_U, FAC_T, FAC_T},
      '{FAC_U, FAC_T, FAC_T, FAC_T}}
  };

  function automatic fac_t fac_sel(input logic [PAL_BITS-1:0] palette,
                                   input logic [1:0] chan,
                                   input logic [1:0] step);
    logic [PAL_BITS-1:0] row;
    row = (palette == PAL_0 || palette == PAL_1) ? palette : PAL_2;
    return FAC_TAB[row][chan][step];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ipc_div_cell.sv
// One restoring-division cell: resolves one quotient bit of t = count / limit.
// Depends on ipc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipc_div_cell #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ipc_pkg::LIMIT_BITS-1:0] limit,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ipc_pkg::LIMIT_BITS:0]  in_rem,
  input  logic [FRACTION_BITS:0]        in_quo,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ipc_pkg::LIMIT_BITS:0]  out_rem,
  output logic [FRACTION_BITS:0]        out_quo
);
  import ipc_pkg::*;

  logic                  ge;
  logic [LIMIT_BITS:0]   diff;
  logic [LIMIT_BITS-1:0] rest;

  // partial remainder stays below twice the limit, so one compare decides the bit
  assign ge       = in_rem >= {1'b0, limit};
  assign diff     = in_rem - {1'b0, limit};
  assign rest     = ge ? diff[LIMIT_BITS-1:0] : in_rem[LIMIT_BITS-1:0];
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // hand the doubled remainder to the next cell
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_rem <= {rest, 1'b0};
      out_quo <= {in_quo[FRACTION_BITS-1:0], ge};
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ipc_mul_cell.sv
// One fixed-point multiply cell: multiplies each channel product by t, u or one.
// Depends on ipc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipc_mul_cell #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  ipc_pkg::fac_set_t                          fac,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic [FRACTION_BITS:0]                     in_t,
  input  logic [FRACTION_BITS:0]                     in_u,
  input  logic [ipc_pkg::CHAN_N-1:0][FRACTION_BITS:0] in_p,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic [FRACTION_BITS:0]                     out_t,
  output logic [FRACTION_BITS:0]                     out_u,
  output logic [ipc_pkg::CHAN_N-1:0][FRACTION_BITS:0] out_p
);
  import ipc_pkg::*;

  localparam int F = FRACTION_BITS;
  localparam int PW = 2 * F + 2;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  logic [CHAN_N-1:0][F:0]    f;
  logic [CHAN_N-1:0][PW-1:0] prod;

  always_comb begin
    for (int c = 0; c < CHAN_N; c++) begin
      unique case (fac[c])
        FAC_T:   f[c] = in_t;
        FAC_U:   f[c] = in_u;
        FAC_ONE: f[c] = ONE;
        default: f[c] = ONE;
      endcase
      prod[c] = PW'(in_p[c]) * PW'(f[c]);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // truncate each product back to F fraction bits; operands never exceed one
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_t <= in_t;
      out_u <= in_u;
      for (int c = 0; c < CHAN_N; c++) begin
        out_p[c] <= prod[c][2*F:F];
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ipc_scale_cell.sv
// Output cell: scales each channel product by 2K * 255, shifts and saturates.
// Depends on ipc_pkg; holds the output beat register.
`timescale 1ns / 1ps
`default_nettype none

module ipc_scale_cell #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic [ipc_pkg::CHAN_N-1:0][FRACTION_BITS:0] in_p,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic [ipc_pkg::CHAN_N-1:0][7:0]            out_rgb
);
  import ipc_pkg::*;

  localparam int F = FRACTION_BITS;
  localparam int PW = F + 1 + SCALE_BITS;

  logic [CHAN_N-1:0][PW-1:0]         prod;
  logic [CHAN_N-1:0][SCALE_BITS-1:0] lvl;
  logic [CHAN_N-1:0][7:0]            sat;

  always_comb begin
    for (int c = 0; c < CHAN_N; c++) begin
      prod[c] = PW'(in_p[c]) * PW'(SCALE[c]);
      lvl[c]  = prod[c][PW-1:F+1];
      sat[c]  = (lvl[c] > SCALE_BITS'(255)) ? 8'hFF : lvl[c][7:0];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_rgb <= sat;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/iteration_palette_color.sv
// Top level of the iteration palette color block: divider chain, multiply chain, output cell.
// Depends on ipc_pkg, ipc_div_cell, ipc_mul_cell, ipc_scale_cell and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "iteration_palette_color_defines.svh"

// Maps the escape-iteration count of one pixel to a 24-bit RGB color. The count is
// clamped to iteration_limit (a limit of zero acts as one), normalized to
// t = count / limit with FRACTION_BITS fraction bits, and each channel is a
// Bernstein-style product of t and u = 1 - t, scaled and saturated at 255. The
// palette register picks one of three formulas (codes other than 0 and 1 act as 2).
// Throughput is one beat per clock unless m_tready stalls the output. There is one cell
// per quotient bit in the restoring-divider chain (FRACTION_BITS + 1 cells), three
// multiply cells, and the output cell that scales, saturates and holds the beat.
// Every cell has its own valid bit, so bubbles collapse and, while a finished color
// waits on m_tready, the input keeps taking beats until every cell holds one. Write
// the registers only while the block is empty.
module iteration_palette_color #(
  parameter int COUNT_BITS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((COUNT_BITS + 7) / 8) * 8 - 1:0] s_tdata,   // iteration_count
  // output stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [23:0]                            m_tdata,   // red, green, blue
  // register writes
  input  logic                                   cfg_we,
  input  logic [ipc_pkg::REG_IDX_BITS-1:0]       cfg_index,
  input  logic [ipc_pkg::LIMIT_BITS-1:0]         cfg_data
);
  import ipc_pkg::*;

  localparam int F      = FRACTION_BITS;
  localparam int DIV_N  = F + 1;
  localparam int MUL_N  = 3;
  localparam int CMP_W  = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [LIMIT_BITS-1:0] iteration_limit;
  logic [PAL_BITS-1:0]   palette_select;
  logic [LIMIT_BITS-1:0] lim_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_limit <= LIMIT_RESET;
      palette_select  <= PAL_0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LIMIT:   iteration_limit <= cfg_data;
        REG_PALETTE: palette_select  <= cfg_data[PAL_BITS-1:0];
        default:     ;
      endcase
    end
  end

  // treat a zero limit as one
  assign lim_eff = (iteration_limit == '0) ? LIMIT_BITS'(1) : iteration_limit;

  // ---------------------------------------------------------------------------
  // Clamp the count to the limit
  // ---------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] count;
  logic [CMP_W-1:0]      count_w;
  logic [CMP_W-1:0]      limit_w;
  logic [CMP_W-1:0]      count_min;

  assign count     = s_tdata[COUNT_BITS-1:0];
  assign count_w   = CMP_W'(count);
  assign limit_w   = CMP_W'(lim_eff);
  assign count_min = (count_w > limit_w) ? limit_w : count_w;

  // ---------------------------------------------------------------------------
  // Divider chain: one quotient bit per cell, MSB (the t == 1.0 bit) first
  // ---------------------------------------------------------------------------
  logic [DIV_N:0]               dv;
  logic [DIV_N:0]               dr;
  logic [DIV_N:0][LIMIT_BITS:0] drem;
  logic [DIV_N:0][F:0]          dquo;

  assign dv[0]    = s_tvalid;
  assign s_tready = dr[0];
  assign drem[0]  = {1'b0, count_min[LIMIT_BITS-1:0]};
  assign dquo[0]  = '0;

  for (genvar i = 0; i < DIV_N; i++) begin : g_div
    ipc_div_cell #(
      .FRACTION_BITS(F)
    ) u_div_cell (
      .clk      (clk),
      .rst      (rst),
      .limit    (lim_eff),
      .in_valid (dv[i]),
      .in_ready (dr[i]),
      .in_rem   (drem[i]),
      .in_quo   (dquo[i]),
      .out_valid(dv[i+1]),
      .out_ready(dr[i+1]),
      .out_rem  (drem[i+1]),
      .out_quo  (dquo[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Multiply chain: start each channel with t or u, then three multiply steps
  // ---------------------------------------------------------------------------
  fac_set_t fac [MUL_N+1];

  for (genvar s = 0; s <= MUL_N; s++) begin : g_fac_step
    for (genvar c = 0; c < CHAN_N; c++) begin : g_fac_chan
      assign fac[s][c] = fac_sel(palette_select, 2'(c), 2'(s));
    end
  end

  logic [MUL_N:0]                mv;
  logic [MUL_N:0]                mr;
  logic [MUL_N:0][F:0]           mt;
  logic [MUL_N:0][F:0]           mu;
  logic [MUL_N:0][CHAN_N-1:0][F:0] mp;

  assign mv[0]     = dv[DIV_N];
  assign dr[DIV_N] = mr[0];
  assign mt[0]     = dquo[DIV_N];
  assign mu[0]     = ONE - dquo[DIV_N];

  for (genvar c = 0; c < CHAN_N; c++) begin : g_start
    assign mp[0][c] = (fac[0][c] == FAC_U) ? mu[0] : mt[0];
  end

  for (genvar s = 0; s < MUL_N; s++) begin : g_mul
    ipc_mul_cell #(
      .FRACTION_BITS(F)
    ) u_mul_cell (
      .clk      (clk),
      .rst      (rst),
      .fac      (fac[s+1]),
      .in_valid (mv[s]),
      .in_ready (mr[s]),
      .in_t     (mt[s]),
      .in_u     (mu[s]),
      .in_p     (mp[s]),
      .out_valid(mv[s+1]),
      .out_ready(mr[s+1]),
      .out_t    (mt[s+1]),
      .out_u    (mu[s+1]),
      .out_p    (mp[s+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Output cell: scale, saturate, hold the beat until taken
  // ---------------------------------------------------------------------------
  logic [CHAN_N-1:0][7:0] rgb;

  ipc_scale_cell #(
    .FRACTION_BITS(F)
  ) u_scale_cell (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mv[MUL_N]),
    .in_ready (mr[MUL_N]),
    .in_p     (mp[MUL_N]),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_rgb  (rgb)
  );

  // red in the low byte
  assign m_tdata = {rgb[2], rgb[1], rgb[0]};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `IPC_ASSERT_NEXT(a_accept_lands, clk, rst, s_tvalid && s_tready, dv[1])
  `IPC_ASSERT_IMPL(a_div_rem, clk, rst, dv[DIV_N], drem[DIV_N][0] == 1'b0 && drem[DIV_N][LIMIT_BITS:1] < lim_eff)
  `IPC_ASSERT_IMPL(a_t_range, clk, rst, dv[DIV_N], dquo[DIV_N] <= ONE)
  `IPC_ASSERT_IMPL(a_p_range, clk, rst, mv[MUL_N], mp[MUL_N][0] <= ONE && mp[MUL_N][1] <= ONE && mp[MUL_N][2] <= ONE)

endmodule

`default_nettype wire
